// ===== hdl/rtt_pkg.sv =====
`default_nettype none
package rtt_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned LenW  = 17;
  localparam int unsigned CntW  = 7;
  localparam int unsigned StW   = 3;
  localparam logic [LenW-1:0] MaxLenReset = 17'd79999;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_REM  = 2'd1,
    REQ_K2U  = 2'd2,
    REQ_U2K  = 2'd3
  } req_t;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_FULL    = 3'd3,
    ST_OVERLAP = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] kern_addr;
    logic [AddrW-1:0] user_addr;
    logic [LenW-1:0]  range_length;
  } in_item_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [AddrW-1:0] translated_addr;
    logic [CntW-1:0]  entry_count;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]       req_type;
    logic             bad_len;
    logic [AddrW-1:0] kern_addr;
    logic [AddrW-1:0] user_addr;
    logic [LenW-1:0]  range_length;
  } cmd_t;

  // x in [b, b+len) without wrap; closed form adds one past the end
  function automatic logic in_range(input logic [AddrW-1:0] x, input logic [AddrW-1:0] b,
                                    input logic [LenW-1:0] len, input logic closed);
    logic [AddrW-1:0] d;
    d = x - b;
    if (x < b) return 1'b0;
    if (d[AddrW-1:LenW] != '0) return 1'b0;
    return closed ? (d[LenW-1:0] <= len) : (d[LenW-1:0] < len);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rtt_ram.sv =====
`default_nettype none
module rtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/rtt_front.sv =====
`default_nettype none
module rtt_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rtt_pkg::in_item_t             in_data,
  input  wire logic [rtt_pkg::LenW-1:0]      max_len,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output rtt_pkg::cmd_t                      cmd
);
  // two-entry queue
  rtt_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  rtt_pkg::cmd_t c;

  always_comb begin
    c.req_type     = in_data.req_type;
    c.kern_addr    = in_data.kern_addr;
    c.user_addr    = in_data.user_addr;
    c.range_length = in_data.range_length;
    c.bad_len      = (in_data.range_length == '0) || (in_data.range_length > max_len);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  logic push, pop;
  assign push = in_valid && in_ready;
  assign pop  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rtt_back.sv =====
`default_nettype none
module rtt_back #(
  parameter int unsigned TableDepth = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire rtt_pkg::cmd_t      cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rtt_pkg::out_item_t      out_data
);
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW   = $clog2(TableDepth + 1);
  localparam int unsigned EW   = 2 * rtt_pkg::AddrW + rtt_pkg::LenW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_SHWR  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t          st_r, st_nxt;
  rtt_pkg::cmd_t   cmd_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   idx_r;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [EW-1:0]   wdata, rdata;
  logic [rtt_pkg::AddrW-1:0] ek, eu;
  logic [rtt_pkg::LenW-1:0]  el;
  rtt_pkg::out_item_t res_r;

  rtt_ram #(.Width(EW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign {ek, eu, el} = rdata;
  assign cmd_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;
  assign raddr     = idx_r[IdxW-1:0];

  logic hit_ov, hit_rm, hit_k, hit_u;
  always_comb begin
    hit_ov = rtt_pkg::in_range(ek, cmd_r.kern_addr, cmd_r.range_length, 1'b0) ||
             rtt_pkg::in_range(cmd_r.kern_addr, ek, el, 1'b0) ||
             rtt_pkg::in_range(eu, cmd_r.user_addr, cmd_r.range_length, 1'b0) ||
             rtt_pkg::in_range(cmd_r.user_addr, eu, el, 1'b0);
    hit_rm = (ek == cmd_r.kern_addr) || (eu == cmd_r.user_addr);
    hit_k  = rtt_pkg::in_range(cmd_r.kern_addr, ek, el, 1'b0);
    hit_u  = rtt_pkg::in_range(cmd_r.user_addr, eu, el, 1'b1);
  end

  logic [rtt_pkg::AddrW-1:0] xl_k, xl_u;
  assign xl_k = eu + (cmd_r.kern_addr - ek);
  assign xl_u = ek + (cmd_r.user_addr - eu);

  logic                      fin;
  logic [rtt_pkg::StW-1:0]   fin_st;
  logic [rtt_pkg::AddrW-1:0] fin_addr;
  logic [CW-1:0]             cnt_nxt, idx_nxt;

  always_comb begin
    st_nxt   = st_r;
    we       = 1'b0;
    waddr    = cnt_r[IdxW-1:0];
    wdata    = {cmd_r.kern_addr, cmd_r.user_addr, cmd_r.range_length};
    fin      = 1'b0;
    fin_st   = rtt_pkg::ST_OK;
    fin_addr = '0;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    case (st_r)
      S_IDLE: if (cmd_valid) begin
        idx_nxt = '0;
        st_nxt  = S_RD;
      end
      S_RD: begin
        if (cmd_r.req_type == rtt_pkg::REQ_ADD && cmd_r.bad_len) begin
          fin = 1'b1; fin_st = rtt_pkg::ST_BADLEN;
        end else if (cmd_r.req_type == rtt_pkg::REQ_ADD &&
                     cnt_r == CW'(TableDepth)) begin
          fin = 1'b1; fin_st = rtt_pkg::ST_FULL;
        end else if (idx_r == cnt_r) begin
          fin = 1'b1;
          if (cmd_r.req_type == rtt_pkg::REQ_ADD) begin
            we = 1'b1; cnt_nxt = cnt_r + 1'b1;
          end else fin_st = rtt_pkg::ST_NOMATCH;
        end else st_nxt = S_CHK;
      end
      S_CHK: begin
        st_nxt  = S_RD;
        idx_nxt = idx_r + 1'b1;
        case (cmd_r.req_type)
          rtt_pkg::REQ_ADD: if (hit_ov) begin
            fin = 1'b1; fin_st = rtt_pkg::ST_OVERLAP;
          end
          rtt_pkg::REQ_REM: if (hit_rm) st_nxt = S_SHIFT;
          rtt_pkg::REQ_K2U: if (hit_k) begin
            fin = 1'b1; fin_addr = xl_k;
          end
          rtt_pkg::REQ_U2K: if (hit_u) begin
            fin = 1'b1; fin_addr = xl_u;
          end
          default: ;
        endcase
      end
      // idx_r points one past the hole; read it, write it back one lower
      S_SHIFT: begin
        if (idx_r == cnt_r) begin
          fin = 1'b1; cnt_nxt = cnt_r - 1'b1;
        end else st_nxt = S_SHWR;
      end
      S_SHWR: begin
        we      = 1'b1;
        waddr   = IdxW'(idx_r - 1'b1);
        wdata   = rdata;
        idx_nxt = idx_r + 1'b1;
        st_nxt  = S_SHIFT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (fin) st_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && cmd_valid) cmd_r <= cmd;
    idx_r <= idx_nxt;
    if (fin) begin
      res_r.status          <= fin_st;
      res_r.translated_addr <= fin_addr;
      res_r.entry_count     <= rtt_pkg::CntW'(cnt_nxt);
    end
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/range_translation_table_unit.sv =====
// Response timing: for a lookup miss, an add that passes or any remove, out_valid follows a
// scan of all N stored entries (a remove shifts the entries behind the match); a lookup hit
// or overlap at entry i ends the scan there; a bad length or full table answers without a scan.
// Throughput: the back end takes one request at a time, scanning the entry RAM (one read and
// one write port) and holding its result on output stall; the front queue holds two beats.
// Reset (synchronous, rst_n low): table empty, max_length 79999; RAM contents unknown.
`default_nettype none
module range_translation_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire rtt_pkg::in_item_t        in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output rtt_pkg::out_item_t            out_data,
  input  wire logic                     cfg_we,
  input  wire logic [rtt_pkg::LenW-1:0] cfg_wdata
);
  logic [rtt_pkg::LenW-1:0] max_len_r;
  logic          cmd_valid, cmd_ready;
  rtt_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= rtt_pkg::MaxLenReset;
    else if (cfg_we) max_len_r <= cfg_wdata;
  end

  rtt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .max_len(max_len_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  rtt_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire
